// ===== hdl/qalu_pkg.sv =====
// shared types and codes for the quaternion alu
`default_nettype none
package qalu_pkg;

    typedef enum logic [1:0] {
        OP_MUL  = 2'd0,
        OP_CONJ = 2'd1,
        OP_NORM = 2'd2,
        OP_MAT  = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_SAT  = 2'd1,
        ST_ZERO = 2'd2
    } t_status;

    typedef struct packed {
        t_op  op;
        logic ovf;
        logic zero;
        logic unit;
    } t_ctl;

endpackage
`default_nettype wire

// ===== hdl/qalu_front.sv =====
// front pipeline: input register, products, sums, rounding and saturation
`default_nettype none
module qalu_front import qalu_pkg::*; #(
    parameter int W  = 16,
    parameter int F  = 14,
    parameter int SW = 33
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_valid,
    input  wire t_op                 i_op,
    input  wire logic [3:0][W-1:0]   i_a,
    input  wire logic [3:0][W-1:0]   i_b,
    output logic                     o_valid,
    output t_ctl                     o_ctl,
    output logic [8:0][W-1:0]        o_res,
    output logic [SW-1:0]            o_s,
    output logic [3:0][W-1:0]        o_a
);

    localparam int AW = 2 * W + 3;
    localparam logic signed [AW-1:0] HALF_Q = AW'(1) <<< (F - 1);
    localparam logic signed [AW-1:0] HALF_M = AW'(1) <<< (F - 2);
    localparam logic signed [AW-1:0] ONE_M  = AW'(1) <<< (2 * F - 1);
    localparam logic signed [AW-1:0] SMAX   = {{(AW-W+1){1'b0}}, {(W-1){1'b1}}};
    localparam logic signed [AW-1:0] SMIN   = {{(AW-W+1){1'b1}}, {(W-1){1'b0}}};
    localparam logic [SW-1:0] S_UNIT = SW'(1) << (2 * F);

    // stage 1
    logic              r1_valid;
    t_op               r1_op;
    logic [3:0][W-1:0] r1_a;
    logic [3:0][W-1:0] r1_b;
    // stage 2
    logic                    r2_valid;
    t_op                     r2_op;
    logic [3:0][W-1:0]       r2_a;
    logic signed [2*W-1:0]   r2_p [4][4];
    // stage 3
    logic                    r3_valid;
    t_op                     r3_op;
    logic [3:0][W-1:0]       r3_a;
    logic signed [AW-1:0]    r3_acc [9];
    logic [SW-1:0]           r3_s;

    logic [3:0][W-1:0]       m;
    logic signed [AW-1:0]    e [4][4];
    logic signed [AW-1:0]    ea [4];
    logic signed [AW-1:0]    n_acc [9];
    logic [2*W:0]            s_full;
    logic [SW-1:0]           n_s;
    logic signed [AW-1:0]    n_sh [9];
    logic [8:0][W-1:0]       n_res;
    logic                    n_ovf;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
            r2_valid <= 1'b0;
            r3_valid <= 1'b0;
            o_valid  <= 1'b0;
        end else begin
            r1_valid <= i_valid;
            r2_valid <= r1_valid;
            r3_valid <= r2_valid;
            o_valid  <= r3_valid;
        end
    end

    assign m = (r1_op == OP_MUL) ? r1_b : r1_a;

    always_ff @(posedge i_clk) begin
        r1_op <= i_op;
        r1_a  <= i_a;
        r1_b  <= i_b;
        r2_op <= r1_op;
        r2_a  <= r1_a;
        for (int i = 0; i < 4; i++) begin
            for (int j = 0; j < 4; j++) begin
                r2_p[i][j] <= $signed(r1_a[i]) * $signed(m[j]);
            end
        end
    end

    always_comb begin
        for (int i = 0; i < 4; i++) begin
            ea[i] = AW'($signed(r2_a[i]));
            for (int j = 0; j < 4; j++) begin
                e[i][j] = AW'(r2_p[i][j]);
            end
        end
    end

    always_comb begin
        for (int k = 0; k < 9; k++) begin
            n_acc[k] = '0;
        end
        unique case (r2_op)
            OP_MUL: begin
                n_acc[0] = e[3][0] + e[0][3] + e[1][2] - e[2][1] + HALF_Q;
                n_acc[1] = e[3][1] + e[1][3] + e[2][0] - e[0][2] + HALF_Q;
                n_acc[2] = e[3][2] + e[2][3] + e[0][1] - e[1][0] + HALF_Q;
                n_acc[3] = e[3][3] - e[0][0] - e[1][1] - e[2][2] + HALF_Q;
            end
            OP_CONJ: begin
                n_acc[0] = -ea[0];
                n_acc[1] = -ea[1];
                n_acc[2] = -ea[2];
                n_acc[3] = ea[3];
            end
            OP_NORM: begin
            end
            OP_MAT: begin
                n_acc[0] = ONE_M - e[1][1] - e[2][2] + HALF_M;
                n_acc[1] = e[0][1] - e[3][2] + HALF_M;
                n_acc[2] = e[0][2] + e[3][1] + HALF_M;
                n_acc[3] = e[0][1] + e[3][2] + HALF_M;
                n_acc[4] = ONE_M - e[0][0] - e[2][2] + HALF_M;
                n_acc[5] = e[1][2] - e[3][0] + HALF_M;
                n_acc[6] = e[0][2] - e[3][1] + HALF_M;
                n_acc[7] = e[1][2] + e[3][0] + HALF_M;
                n_acc[8] = ONE_M - e[0][0] - e[1][1] + HALF_M;
            end
        endcase
    end

    // sum of squares, clamped to the length register
    assign s_full = (2*W+1)'($unsigned(r2_p[0][0])) + (2*W+1)'($unsigned(r2_p[1][1]))
                  + (2*W+1)'($unsigned(r2_p[2][2])) + (2*W+1)'($unsigned(r2_p[3][3]));
    assign n_s = (|(s_full >> SW)) ? '1 : s_full[SW-1:0];

    always_ff @(posedge i_clk) begin
        r3_op <= r2_op;
        r3_a  <= r2_a;
        r3_s  <= n_s;
        for (int k = 0; k < 9; k++) begin
            r3_acc[k] <= n_acc[k];
        end
    end

    always_comb begin
        n_ovf = 1'b0;
        for (int k = 0; k < 9; k++) begin
            unique case (r3_op)
                OP_MUL:  n_sh[k] = r3_acc[k] >>> F;
                OP_MAT:  n_sh[k] = r3_acc[k] >>> (F - 1);
                default: n_sh[k] = r3_acc[k];
            endcase
            if (n_sh[k] > SMAX) begin
                n_res[k] = SMAX[W-1:0];
                n_ovf    = 1'b1;
            end else if (n_sh[k] < SMIN) begin
                n_res[k] = SMIN[W-1:0];
                n_ovf    = 1'b1;
            end else begin
                n_res[k] = n_sh[k][W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        o_ctl.op   <= r3_op;
        o_ctl.ovf  <= n_ovf;
        o_ctl.zero <= (r3_s == '0);
        o_ctl.unit <= (r3_s == S_UNIT);
        o_res      <= n_res;
        o_s        <= r3_s;
        o_a        <= r3_a;
    end

endmodule
`default_nettype wire

// ===== hdl/qalu_sqrt.sv =====
// pipelined integer square root, one root bit per stage
`default_nettype none
module qalu_sqrt #(
    parameter int SW = 33,
    parameter int NR = 17
) (
    input  wire logic          i_clk,
    input  wire logic [SW-1:0] i_s,
    output logic [NR-1:0]      o_root
);

    localparam int XW = 2 * NR;
    localparam int RW = NR + 3;

    logic [XW-1:0] r_x    [NR];
    logic [RW-1:0] r_rem  [NR];
    logic [NR-1:0] r_root [NR];

    for (genvar k = 0; k < NR; k++) begin : g_stage
        logic [XW-1:0] x_in;
        logic [RW-1:0] rem_in;
        logic [NR-1:0] root_in;
        logic [RW-1:0] rem2;
        logic [RW-1:0] trial;
        logic          ge;

        if (k == 0) begin : g_first
            assign x_in    = XW'(i_s);
            assign rem_in  = '0;
            assign root_in = '0;
        end else begin : g_next
            assign x_in    = r_x[k-1];
            assign rem_in  = r_rem[k-1];
            assign root_in = r_root[k-1];
        end

        assign rem2  = {rem_in[RW-3:0], x_in[XW-1 -: 2]};
        assign trial = RW'({root_in, 2'b01});
        assign ge    = (rem2 >= trial);

        always_ff @(posedge i_clk) begin
            r_x[k]    <= x_in << 2;
            r_rem[k]  <= ge ? (rem2 - trial) : rem2;
            r_root[k] <= {root_in[NR-2:0], ge};
        end
    end

    assign o_root = r_root[NR-1];

endmodule
`default_nettype wire

// ===== hdl/qalu_div.sv =====
// pipelined restoring divider, four lanes sharing one divisor
`default_nettype none
module qalu_div #(
    parameter int W  = 16,
    parameter int F  = 14,
    parameter int NR = 17
) (
    input  wire logic                   i_clk,
    input  wire logic [3:0][W-1:0]      i_mag,
    input  wire logic [NR-1:0]          i_len,
    output logic [3:0][W+F:0]           o_quo
);

    localparam int DW = W + F + 1;

    logic [3:0][DW-1:0] r_n   [DW];
    logic [3:0][NR-1:0] r_rem [DW];
    logic [3:0][DW-1:0] r_q   [DW];
    logic [NR-1:0]      r_len [DW];

    for (genvar j = 0; j < DW; j++) begin : g_stage
        logic [3:0][DW-1:0] n_in;
        logic [3:0][NR-1:0] rem_in;
        logic [3:0][DW-1:0] q_in;
        logic [NR-1:0]      len_in;
        logic [3:0][NR:0]   t;
        logic [3:0]         ge;

        if (j == 0) begin : g_first
            // dividend with half the divisor added for rounding
            for (genvar l = 0; l < 4; l++) begin : g_lane
                assign n_in[l] = DW'({i_mag[l], {F{1'b0}}}) + DW'(i_len >> 1);
            end
            assign rem_in = '0;
            assign q_in   = '0;
            assign len_in = i_len;
        end else begin : g_next
            assign n_in   = r_n[j-1];
            assign rem_in = r_rem[j-1];
            assign q_in   = r_q[j-1];
            assign len_in = r_len[j-1];
        end

        for (genvar l = 0; l < 4; l++) begin : g_cmp
            assign t[l]  = {rem_in[l], n_in[l][DW-1]};
            assign ge[l] = (t[l] >= {1'b0, len_in});
        end

        always_ff @(posedge i_clk) begin
            r_len[j] <= len_in;
            for (int l = 0; l < 4; l++) begin
                r_n[j][l]   <= n_in[l] << 1;
                r_rem[j][l] <= ge[l] ? NR'(t[l] - {1'b0, len_in}) : NR'(t[l]);
                r_q[j][l]   <= {q_in[l][DW-2:0], ge[l]};
            end
        end
    end

    assign o_quo = r_q[DW-1];

endmodule
`default_nettype wire

// ===== hdl/quaternion_alu.sv =====
// top level of the fixed-point quaternion alu
//
// command channel: an item is taken at a clock edge with start high and
// busy low; busy stays low, so one item can be taken every cycle.
// each item gives exactly one result, shown on the o_ ports for one cycle
// with o_valid high; the receiver cannot hold it off.
// each item passes the front's input, product, sum and output registers,
// the square root pipeline of depth NR = ceil(min(2*WORD_BITS+1, 64) / 2),
// the divider pipeline used by normalize, of depth DW = WORD_BITS +
// FRAC_BITS + 1, and a final output register.
// every operation travels through the same stages, so results leave in
// order at one per cycle.
// ops: multiply, conjugate, normalize, rotation matrix (row-major).
// status: ok, saturated, or normalize of zero length.
// reset is synchronous and clears only the valid bits; items in flight
// are dropped and no result appears in the cycle after reset.
`default_nettype none
module quaternion_alu import qalu_pkg::*; #(
    parameter int WORD_BITS = 16,
    parameter int FRAC_BITS = 14
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        start,
    output logic                             busy,
    input  wire logic [1:0]                  i_req_type,
    input  wire logic signed [WORD_BITS-1:0] i_a_x,
    input  wire logic signed [WORD_BITS-1:0] i_a_y,
    input  wire logic signed [WORD_BITS-1:0] i_a_z,
    input  wire logic signed [WORD_BITS-1:0] i_a_w,
    input  wire logic signed [WORD_BITS-1:0] i_b_x,
    input  wire logic signed [WORD_BITS-1:0] i_b_y,
    input  wire logic signed [WORD_BITS-1:0] i_b_z,
    input  wire logic signed [WORD_BITS-1:0] i_b_w,
    output logic                             o_valid,
    output logic signed [WORD_BITS-1:0]      o_out_0,
    output logic signed [WORD_BITS-1:0]      o_out_1,
    output logic signed [WORD_BITS-1:0]      o_out_2,
    output logic signed [WORD_BITS-1:0]      o_out_3,
    output logic signed [WORD_BITS-1:0]      o_out_4,
    output logic signed [WORD_BITS-1:0]      o_out_5,
    output logic signed [WORD_BITS-1:0]      o_out_6,
    output logic signed [WORD_BITS-1:0]      o_out_7,
    output logic signed [WORD_BITS-1:0]      o_out_8,
    output logic [1:0]                       o_status
);

    localparam int W    = WORD_BITS;
    localparam int F    = FRAC_BITS;
    localparam int SW   = (2 * W + 1 > 64) ? 64 : 2 * W + 1;
    localparam int NR   = (SW + 1) / 2;
    localparam int DW   = W + F + 1;
    localparam int SDEP = NR + DW;
    localparam int LAT  = 5 + NR + DW;
    localparam logic [DW-1:0] QPOS = {{(DW-W+1){1'b0}}, {(W-1){1'b1}}};
    localparam logic [DW-1:0] QNEG = {{(DW-W){1'b0}}, 1'b1, {(W-1){1'b0}}};
    localparam logic [W-1:0]  WMAX = {1'b0, {(W-1){1'b1}}};
    localparam logic [W-1:0]  WMIN = {1'b1, {(W-1){1'b0}}};

    logic              in_xfer;
    logic [3:0][W-1:0] a_in;
    logic [3:0][W-1:0] b_in;

    logic              f_valid;
    t_ctl              f_ctl;
    logic [8:0][W-1:0] f_res;
    logic [SW-1:0]     f_s;
    logic [3:0][W-1:0] f_a;

    logic [NR-1:0]     sq_root;
    logic [3:0][W-1:0] d_mag;
    logic [3:0][DW-1:0] d_quo;

    logic              r_vld [SDEP];
    t_ctl              r_ctl [SDEP];
    logic [8:0][W-1:0] r_res [SDEP];
    logic [3:0][W-1:0] r_a   [SDEP];

    t_ctl              fin_ctl;
    logic [3:0][W-1:0] fin_a;
    logic [8:0][W-1:0] n_out;
    logic              n_ovf;
    t_status           n_status;
    logic              r_valid;
    logic [8:0][W-1:0] r_out;
    t_status           r_status;

    assign busy    = 1'b0;
    assign in_xfer = start && !busy;
    assign a_in    = {i_a_w, i_a_z, i_a_y, i_a_x};
    assign b_in    = {i_b_w, i_b_z, i_b_y, i_b_x};

    qalu_front #(.W(W), .F(F), .SW(SW)) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (in_xfer),
        .i_op    (t_op'(i_req_type)),
        .i_a     (a_in),
        .i_b     (b_in),
        .o_valid (f_valid),
        .o_ctl   (f_ctl),
        .o_res   (f_res),
        .o_s     (f_s),
        .o_a     (f_a)
    );

    qalu_sqrt #(.SW(SW), .NR(NR)) u_sqrt (
        .i_clk  (i_clk),
        .i_s    (f_s),
        .o_root (sq_root)
    );

    // magnitudes line up with the root leaving the square root pipeline
    always_comb begin
        for (int l = 0; l < 4; l++) begin
            d_mag[l] = r_a[NR-1][l][W-1] ? W'(-r_a[NR-1][l]) : r_a[NR-1][l];
        end
    end

    qalu_div #(.W(W), .F(F), .NR(NR)) u_div (
        .i_clk (i_clk),
        .i_mag (d_mag),
        .i_len (sq_root),
        .o_quo (d_quo)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < SDEP; k++) begin
                r_vld[k] <= 1'b0;
            end
        end else begin
            r_vld[0] <= f_valid;
            for (int k = 1; k < SDEP; k++) begin
                r_vld[k] <= r_vld[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_ctl[0] <= f_ctl;
        r_res[0] <= f_res;
        r_a[0]   <= f_a;
        for (int k = 1; k < SDEP; k++) begin
            r_ctl[k] <= r_ctl[k-1];
            r_res[k] <= r_res[k-1];
            r_a[k]   <= r_a[k-1];
        end
    end

    assign fin_ctl = r_ctl[SDEP-1];
    assign fin_a   = r_a[SDEP-1];

    always_comb begin
        n_out = '0;
        n_ovf = 1'b0;
        if (fin_ctl.op != OP_NORM) begin
            n_out = r_res[SDEP-1];
            n_ovf = fin_ctl.ovf;
        end else if (fin_ctl.unit) begin
            for (int l = 0; l < 4; l++) begin
                n_out[l] = fin_a[l];
            end
        end else begin
            for (int l = 0; l < 4; l++) begin
                if (!fin_a[l][W-1]) begin
                    if (d_quo[l] > QPOS) begin
                        n_out[l] = WMAX;
                        n_ovf    = 1'b1;
                    end else begin
                        n_out[l] = d_quo[l][W-1:0];
                    end
                end else begin
                    if (d_quo[l] > QNEG) begin
                        n_out[l] = WMIN;
                        n_ovf    = 1'b1;
                    end else begin
                        n_out[l] = W'(-d_quo[l][W-1:0]);
                    end
                end
            end
        end
    end

    always_comb begin
        priority if (fin_ctl.op == OP_NORM && fin_ctl.zero) begin
            n_status = ST_ZERO;
        end else if (n_ovf) begin
            n_status = ST_SAT;
        end else begin
            n_status = ST_OK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= r_vld[SDEP-1];
        end
    end

    always_ff @(posedge i_clk) begin
        r_status <= n_status;
        if (fin_ctl.op == OP_NORM && fin_ctl.zero) begin
            r_out <= '0;
        end else begin
            r_out <= n_out;
        end
    end

    assign o_valid  = r_valid;
    assign o_status = r_status;
    assign o_out_0  = r_out[0];
    assign o_out_1  = r_out[1];
    assign o_out_2  = r_out[2];
    assign o_out_3  = r_out[3];
    assign o_out_4  = r_out[4];
    assign o_out_5  = r_out[5];
    assign o_out_6  = r_out[6];
    assign o_out_7  = r_out[7];
    assign o_out_8  = r_out[8];

`ifndef ASSERT_OFF
    a_no_result_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result strobe right after reset");

    a_fixed_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_xfer |-> ##LAT o_valid)
        else $error("result missing at fixed latency");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_status == ST_OK || o_status == ST_SAT || o_status == ST_ZERO))
        else $error("unused status code");

    a_zero_length_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status == ST_ZERO) |->
            (o_out_0 == '0 && o_out_1 == '0 && o_out_2 == '0 && o_out_3 == '0 &&
             o_out_4 == '0 && o_out_5 == '0 && o_out_6 == '0 && o_out_7 == '0 &&
             o_out_8 == '0))
        else $error("zero-length normalize with nonzero result");
`endif

endmodule
`default_nettype wire
